### src/tcta_pkg.sv
`timescale 1ns / 1ps

package tcta_pkg;

  // Field widths of one sensor record and one result.
  localparam int SAMPLE_WIDTH = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int NUM_CH       = 3;
  localparam int ALERT_WIDTH  = 3;
  localparam int STATUS_WIDTH = 2;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 64;

  // Packed tdata widths, rounded up to whole bytes.
  localparam int IN_FIELD_BITS  = NUM_CH * SAMPLE_WIDTH + TIME_WIDTH;
  localparam int IN_DATA_WIDTH  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = STATUS_WIDTH + NUM_CH * ALERT_WIDTH;
  localparam int OUT_DATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [TIME_WIDTH-1:0]          time_t;
  typedef logic [ALERT_WIDTH-1:0]         alert_t;
  typedef logic [STATUS_WIDTH-1:0]        status_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]     cfg_index_t;

  // Register indexes.
  localparam cfg_index_t CFG_TEMP_THR  = 3'd0;
  localparam cfg_index_t CFG_PULSE_THR = 3'd1;
  localparam cfg_index_t CFG_WBGT_THR  = 3'd2;
  localparam cfg_index_t CFG_WARN_INT  = 3'd3;
  localparam cfg_index_t CFG_CRIT_INT  = 3'd4;

  // Threshold slot positions inside a packed threshold register.
  localparam int SLOT_CRIT_LO = 0;
  localparam int SLOT_CRIT_HI = 1;
  localparam int SLOT_WARN_LO = 2;
  localparam int SLOT_WARN_HI = 3;

  // Alert codes.
  localparam alert_t AL_NONE     = 3'd0;
  localparam alert_t AL_WARN_ON  = 3'd1;
  localparam alert_t AL_WARN_REP = 3'd2;
  localparam alert_t AL_CRIT_ON  = 3'd3;
  localparam alert_t AL_CRIT_REP = 3'd4;

  // Overall status codes.
  localparam status_t ST_NORMAL   = 2'd0;
  localparam status_t ST_WARNING  = 2'd1;
  localparam status_t ST_CRITICAL = 2'd2;

  // Reset values of the repeat intervals in milliseconds.
  localparam time_t WARN_INT_RESET = 32'd60000;
  localparam time_t CRIT_INT_RESET = 32'd1000;

endpackage

### src/three_channel_threshold_alarm.sv
`timescale 1ns / 1ps

// Three channel threshold alarm.
//
// The in_ stream carries one sensor record per request: skin temperature, heart
// rate and WBGT as signed Q11.4 samples plus a wrapping millisecond time stamp.
// The out_ stream returns exactly one result per record: the overall status and
// one alert code per channel (onset or repeat, warning or critical).
// The cfg_ channel writes the three packed threshold registers and the two
// repeat intervals; it is always ready and must only be used while idle.
// The datapath has an input register and a result register with the channel
// compares and flag updates between them. An accepted record goes from the input
// register to the result register that drives out_tdata, and a new record is taken
// every cycle, so throughput is one record per clock as long as out_tready is high.
// When the receiver stalls, the result register holds; the input register
// still takes one more record, then in_tready drops until the result leaves.
// A synchronous active low reset empties both stages, clears all warning and
// critical flags and last alert times, zeroes the thresholds and loads the
// interval registers with 60000 ms (warning) and 1000 ms (critical).
module three_channel_threshold_alarm
  import tcta_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // Input records.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // From bit 0: skin_temp[15:0], pulse_rate[15:0], wbgt_level[15:0], time_ms[31:0].
  input  logic [IN_DATA_WIDTH-1:0]   in_tdata,
  // Results.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // From bit 0: overall_status[1:0], temp_alert[2:0], pulse_alert[2:0],
  // wbgt_alert[2:0], zero padding.
  output logic [OUT_DATA_WIDTH-1:0]  out_tdata,
  // Configuration writes.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  // Configuration registers.
  logic [CFG_DATA_WIDTH-1:0] thr_r [NUM_CH];
  time_t                     warn_int_r;
  time_t                     crit_int_r;

  // Per-channel state.
  logic  [NUM_CH-1:0] warn_flag_r;
  logic  [NUM_CH-1:0] warn_flag_nxt;
  logic  [NUM_CH-1:0] crit_flag_r;
  logic  [NUM_CH-1:0] crit_flag_nxt;
  time_t              last_time_r   [NUM_CH];
  time_t              last_time_nxt [NUM_CH];

  // Input register stage.
  logic    s1_valid_r;
  sample_t s1_sample_r [NUM_CH];
  time_t   s1_time_r;

  // Result register stage.
  logic    out_valid_r;
  status_t status_r;
  status_t status_nxt;
  alert_t  alert_r   [NUM_CH];
  alert_t  alert_nxt [NUM_CH];

  logic advance;
  logic in_fire;

  // The input stage moves into the result stage whenever the result register is
  // empty or being drained this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Channel classification. Critical band [lo,hi] is tested before the warning
  // band [lo,hi). A drop from critical into warning gives no onset, but a
  // repeat may still fire against the warning interval.
  always_comb begin
    sample_t cl;
    sample_t chi;
    sample_t wl;
    sample_t wh;
    time_t   elapsed;
    logic    in_crit;
    logic    in_warn;
    logic [STATUS_WIDTH-1:0] st;
    st = ST_NORMAL;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cl  = sample_t'(thr_r[ch][SLOT_CRIT_LO*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
      chi = sample_t'(thr_r[ch][SLOT_CRIT_HI*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
      wl  = sample_t'(thr_r[ch][SLOT_WARN_LO*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
      wh  = sample_t'(thr_r[ch][SLOT_WARN_HI*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
      // Modular time since this channel's last alert.
      elapsed = s1_time_r - last_time_r[ch];
      in_crit = (s1_sample_r[ch] >= cl) && (s1_sample_r[ch] <= chi);
      in_warn = (s1_sample_r[ch] >= wl) && (s1_sample_r[ch] < wh);

      alert_nxt[ch]     = AL_NONE;
      warn_flag_nxt[ch] = warn_flag_r[ch];
      crit_flag_nxt[ch] = crit_flag_r[ch];
      if (in_crit) begin
        if (!crit_flag_r[ch]) begin
          crit_flag_nxt[ch] = 1'b1;
          alert_nxt[ch]     = AL_CRIT_ON;
        end else if (elapsed >= crit_int_r) begin
          alert_nxt[ch] = AL_CRIT_REP;
        end
        warn_flag_nxt[ch] = 1'b0;
      end else if (in_warn) begin
        if (!warn_flag_r[ch] && !crit_flag_r[ch]) begin
          warn_flag_nxt[ch] = 1'b1;
          alert_nxt[ch]     = AL_WARN_ON;
        end else if (elapsed >= warn_int_r) begin
          alert_nxt[ch] = AL_WARN_REP;
        end
        crit_flag_nxt[ch] = 1'b0;
      end else begin
        warn_flag_nxt[ch] = 1'b0;
        crit_flag_nxt[ch] = 1'b0;
      end

      last_time_nxt[ch] = (alert_nxt[ch] != AL_NONE) ? s1_time_r : last_time_r[ch];
    end

    // Status reflects the flags after this record's updates.
    if (|crit_flag_nxt) begin
      st = ST_CRITICAL;
    end else if (|warn_flag_nxt) begin
      st = ST_WARNING;
    end
    status_nxt = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      warn_flag_r <= '0;
      crit_flag_r <= '0;
      warn_int_r  <= WARN_INT_RESET;
      crit_int_r  <= CRIT_INT_RESET;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        last_time_r[ch] <= '0;
        thr_r[ch]       <= '0;
      end
    end else begin
      // Input stage: it empties when it advances and fills on a new request.
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      // Result stage and channel state move together.
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          warn_flag_r <= warn_flag_nxt;
          crit_flag_r <= crit_flag_nxt;
          for (int ch = 0; ch < NUM_CH; ch++) begin
            last_time_r[ch] <= last_time_nxt[ch];
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TEMP_THR:  thr_r[0]   <= cfg_data;
          CFG_PULSE_THR: thr_r[1]   <= cfg_data;
          CFG_WBGT_THR:  thr_r[2]   <= cfg_data;
          CFG_WARN_INT:  warn_int_r <= cfg_data[TIME_WIDTH-1:0];
          CFG_CRIT_INT:  crit_int_r <= cfg_data[TIME_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s1_sample_r[ch] <= sample_t'(in_tdata[ch*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
      end
      s1_time_r <= in_tdata[NUM_CH*SAMPLE_WIDTH +: TIME_WIDTH];
    end
    if (advance && s1_valid_r) begin
      status_r <= status_nxt;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        alert_r[ch] <= alert_nxt[ch];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_WIDTH - OUT_FIELD_BITS){1'b0}},
                       alert_r[2], alert_r[1], alert_r[0], status_r};

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb
  import tcta_pkg::*;
;

  // One sensor record as it travels on in_tdata, skin temperature in the low bits.
  typedef struct packed {
    time_t   stamp;
    sample_t wbgt;
    sample_t pulse;
    sample_t temp;
  } sensor_record_t;

  // One result as it travels on out_tdata, overall status in the low bits.
  typedef struct packed {
    alert_t  wbgt;
    alert_t  pulse;
    alert_t  temp;
    status_t status;
  } alarm_result_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [IN_DATA_WIDTH-1:0]   in_tdata  = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0]  out_tdata;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

  three_channel_threshold_alarm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our own copy of the alarm configuration. It only changes while the block is idle,
  // so the predictor can always work with the values that the block holds.
  logic [63:0] band_regs [NUM_CH] = '{default: '0};
  time_t       warn_gap = WARN_INT_RESET;
  time_t       crit_gap = CRIT_INT_RESET;

  // Per channel alarm state, mirrored from what the block must keep.
  logic  warn_flag     [NUM_CH] = '{default: 1'b0};
  logic  crit_flag     [NUM_CH] = '{default: 1'b0};
  time_t last_alert_ms [NUM_CH] = '{default: '0};

  sensor_record_t sensor_backlog   [$];   // records not yet offered to the block
  alarm_result_t  predicted_alarms [$];   // results owed by the block, oldest first
  sensor_record_t offered_record;
  alarm_result_t  due_alarm;
  alarm_result_t  seen_alarm;
  int unsigned    send_gap    = 0;
  int unsigned    hold_ready  = 0;
  int unsigned    mismatch_count = 0;
  bit             steady_flow = 1'b0;
  time_t          clock_ms    = '0;

  // Directed temperature walk: normal, warning onset and repeat, critical onset and
  // repeat, the drop back to warning with and without a repeat, both inclusive
  // critical edges, the exclusive warning edge and a repeat across the time wrap.
  int    temp_steps [17] = '{0, 600, 600, 600, 700, 700, 700, 600, 600, 700, 600,
                             640, 800, 801, 560, 639, 559};
  time_t stamp_steps[17] = '{32'd0, 32'd0, 32'd50, 32'd100, 32'd105, 32'd110, 32'd115,
                             32'd120, 32'd121, 32'd200, 32'd400, 32'd401, 32'd402,
                             32'd403, 32'hFFFF_FFF0, 32'h0000_0054, 32'hFFFF_FFFF};
  // Heart rate and WBGT walk over the extremes and around their odd bands meanwhile.
  int    probe_levels[11] = '{-32768, 32767, 0, -1, 1, 50, 75, 100, -100, 32000, 32766};

  function automatic sample_t band_edge(int ch, int k);
    return band_regs[ch][k*SAMPLE_WIDTH +: SAMPLE_WIDTH];
  endfunction

  function automatic logic [63:0] pack_bands(int cl, int chi, int wl, int wh);
    return {wh[15:0], wl[15:0], chi[15:0], cl[15:0]};
  endfunction

  // Classifies one sample of one channel and updates that channel's flags. The
  // critical band wins over the warning band; after a drop from critical the
  // warning flag stays clear, so only a repeat can fire on that sample.
  function automatic alert_t rate_channel(int ch, sample_t level, time_t stamp);
    sample_t crit_lo, crit_hi, warn_lo, warn_hi;
    time_t   elapsed;
    logic    was_crit;
    alert_t  alert;
    crit_lo  = band_edge(ch, SLOT_CRIT_LO);
    crit_hi  = band_edge(ch, SLOT_CRIT_HI);
    warn_lo  = band_edge(ch, SLOT_WARN_LO);
    warn_hi  = band_edge(ch, SLOT_WARN_HI);
    was_crit = crit_flag[ch];
    elapsed  = stamp - last_alert_ms[ch];
    alert    = AL_NONE;
    if (level >= crit_lo && level <= crit_hi) begin
      if (!crit_flag[ch]) begin
        crit_flag[ch] = 1'b1;
        alert = AL_CRIT_ON;
      end else if (elapsed >= crit_gap) begin
        alert = AL_CRIT_REP;
      end
      warn_flag[ch] = 1'b0;
    end else if (level >= warn_lo && level < warn_hi) begin
      if (!warn_flag[ch] && !was_crit) begin
        warn_flag[ch] = 1'b1;
        alert = AL_WARN_ON;
      end else if (elapsed >= warn_gap) begin
        alert = AL_WARN_REP;
      end
      crit_flag[ch] = 1'b0;
    end else begin
      warn_flag[ch] = 1'b0;
      crit_flag[ch] = 1'b0;
    end
    if (alert != AL_NONE) last_alert_ms[ch] = stamp;
    return alert;
  endfunction

  function automatic alarm_result_t predict_alarm(sensor_record_t rec);
    alarm_result_t res;
    res.temp   = rate_channel(0, rec.temp, rec.stamp);
    res.pulse  = rate_channel(1, rec.pulse, rec.stamp);
    res.wbgt   = rate_channel(2, rec.wbgt, rec.stamp);
    res.status = ST_NORMAL;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (crit_flag[ch]) res.status = ST_CRITICAL;
      else if (warn_flag[ch] && res.status == ST_NORMAL) res.status = ST_WARNING;
    end
    return res;
  endfunction

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Samples cluster on the band edges and inside the bands so that channels dwell
  // in a band long enough to reach repeats; the rest covers the whole range.
  function automatic sample_t pick_sample(int ch);
    int cl, chi, wl, wh, r;
    cl  = band_edge(ch, SLOT_CRIT_LO);
    chi = band_edge(ch, SLOT_CRIT_HI);
    wl  = band_edge(ch, SLOT_WARN_LO);
    wh  = band_edge(ch, SLOT_WARN_HI);
    r   = $urandom_range(99);
    if (r < 12) return sample_t'($urandom);
    if (r < 16) return sample_t'(probe_levels[$urandom_range(3)]);
    if (r < 40) return sample_t'(int'(band_edge(ch, $urandom_range(3))) +
                                 int'($urandom_range(4)) - 2);
    if (r < 70 && cl <= chi) return sample_t'(cl + int'($urandom_range(chi - cl)));
    if (r < 95 && wl < wh) return sample_t'(wl + int'($urandom_range(wh - wl - 1)));
    return sample_t'($urandom);
  endfunction

  // Time advances in steps that land just before, on and just after each repeat
  // interval, with occasional wild jumps that also carry the time across the wrap.
  function automatic time_t next_step();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 40) return $urandom_range(1, 20);
    if (r < 55) return crit_gap + $urandom_range(2) - 1;
    if (r < 70) return warn_gap + $urandom_range(2) - 1;
    if (r < 75) return $urandom;
    return $urandom_range(1, 400);
  endfunction

  function automatic logic [63:0] make_bands(int style);
    int a, b, c;
    a = int'($urandom_range(2000)) - 1000;
    b = a + int'($urandom_range(1, 300));
    c = b + int'($urandom_range(1, 300));
    case (style)
      0: return pack_bands(b, c, a, b);            // warning just below a high critical band
      1: return pack_bands(a, b, b, c);            // low critical band, warning above it
      2: return {$urandom, $urandom};              // anything, inverted bands included
      default: return pack_bands(a, c, b - 50, b + 50);  // warning mostly hidden by critical
    endcase
  endfunction

  function automatic time_t random_interval();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return $urandom;
    return $urandom_range(1, 300);
  endfunction

  function automatic void check_field(string label, logic [15:0] due, logic [15:0] seen);
    if (seen !== due) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, due, seen);
      mismatch_count++;
    end
  endfunction

  task automatic queue_record(sample_t temp, sample_t pulse, sample_t wbgt, time_t stamp);
    sensor_record_t rec;
    rec.temp  = temp;
    rec.pulse = pulse;
    rec.wbgt  = wbgt;
    rec.stamp = stamp;
    sensor_backlog.push_back(rec);
  endtask

  // One configuration request; our copy follows at the edge where it is taken.
  task automatic write_register(cfg_index_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEMP_THR:  band_regs[0] = value;
      CFG_PULSE_THR: band_regs[1] = value;
      CFG_WBGT_THR:  band_regs[2] = value;
      CFG_WARN_INT:  warn_gap = value[TIME_WIDTH-1:0];
      CFG_CRIT_INT:  crit_gap = value[TIME_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic program_phase(int phase);
    logic [63:0] bands [NUM_CH];
    time_t       warn_ms, crit_ms;
    for (int ch = 0; ch < NUM_CH; ch++) bands[ch] = make_bands($urandom_range(3));
    warn_ms = random_interval();
    crit_ms = random_interval();
    case (phase)
      0: begin
        // Zero intervals: every sample that stays in a band repeats.
        warn_ms = '0;
        crit_ms = '0;
      end
      1: begin
        // Largest intervals: a repeat needs an elapsed time of all ones, one short of a full wrap.
        warn_ms = '1;
        crit_ms = '1;
      end
      2: begin
        bands[0] = '1;
        bands[1] = pack_bands(-32768, 32767, 0, 100);
      end
      3: begin
        for (int ch = 0; ch < NUM_CH; ch++) bands[ch] = {$urandom, $urandom};
      end
      default: ;
    endcase
    write_register(CFG_TEMP_THR, bands[0]);
    write_register(CFG_PULSE_THR, bands[1]);
    write_register(CFG_WBGT_THR, bands[2]);
    write_register(CFG_WARN_INT, 64'(warn_ms));
    write_register(CFG_CRIT_INT, 64'(crit_ms));
  endtask

  task automatic queue_random_records(int count);
    for (int n = 0; n < count; n++) begin
      clock_ms += next_step();
      queue_record(pick_sample(0), pick_sample(1), pick_sample(2), clock_ms);
    end
  endtask

  // Every record yields one result, so the block is idle once nothing is left to
  // offer and every predicted result has come back.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (sensor_backlog.size() != 0 || in_tvalid || predicted_alarms.size() != 0);
  endtask

  // Record driver. A request is taken at an edge where in_tvalid and in_tready are
  // both high; the expected result is worked out right then, against the state
  // that all earlier records left behind. A new record, or a pause, is chosen only
  // when the current one has gone, so in_tvalid never drops while a request waits.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predicted_alarms.push_back(predict_alarm(offered_record));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (sensor_backlog.size() > 0) begin
          offered_record = sensor_backlog.pop_front();
          in_tdata  <= IN_DATA_WIDTH'(offered_record);
          in_tvalid <= 1'b1;
          send_gap  = idle_length();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result request is compared field by field with the
  // oldest prediction; out_tready is withheld at random to stall the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_alarms.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          due_alarm  = predicted_alarms.pop_front();
          seen_alarm = alarm_result_t'(out_tdata[OUT_FIELD_BITS-1:0]);
          check_field("overall_status", 16'(due_alarm.status), 16'(seen_alarm.status));
          check_field("temp_alert", 16'(due_alarm.temp), 16'(seen_alarm.temp));
          check_field("pulse_alert", 16'(due_alarm.pulse), 16'(seen_alarm.pulse));
          check_field("wbgt_alert", 16'(due_alarm.wbgt), 16'(seen_alarm.wbgt));
          check_field("out_tdata padding", '0,
                      16'(out_tdata[OUT_DATA_WIDTH-1:OUT_FIELD_BITS]));
        end
      end
      if (hold_ready > 0) begin
        hold_ready--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(3) == 0) hold_ready = idle_length();
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: every band reads [0,0], the warning band is empty, and
    // the intervals hold their reset values, so a critical repeat needs 1000 ms.
    queue_record(0, 0, 0, 32'd0);
    queue_record(0, 0, 0, 32'd999);
    queue_record(0, 0, 0, 32'd1000);
    queue_record(sample_t'(-32768), sample_t'(-32768), sample_t'(-32768), 32'hFFFF_FFFF);
    queue_record(32767, 32767, 32767, 32'd1000);
    wait_until_drained();

    // Directed bands: temperature has plain bands, heart rate an inverted critical
    // band under an almost full warning band, WBGT bands at both ends of the range.
    write_register(CFG_TEMP_THR, pack_bands(640, 800, 560, 640));
    write_register(CFG_PULSE_THR, pack_bands(100, 50, -32768, 32767));
    write_register(CFG_WBGT_THR, pack_bands(-32768, -100, 32000, 32767));
    write_register(CFG_WARN_INT, 64'd100);
    write_register(CFG_CRIT_INT, 64'd10);
    @(negedge clk);
    for (int n = 0; n < 17; n++)
      queue_record(sample_t'(temp_steps[n]), sample_t'(probe_levels[n % 11]),
                   sample_t'(probe_levels[(n + 5) % 11]), stamp_steps[n]);
    wait_until_drained();
    clock_ms = 32'hFFFF_0000;

    // Random part: a fresh configuration per phase, some phases without any idling.
    for (int phase = 0; phase < 12; phase++) begin
      program_phase(phase);
      steady_flow = (phase % 5 == 4);
      @(negedge clk);
      queue_random_records(162);
      wait_until_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### three_channel_threshold_alarm.f
src/tcta_pkg.sv
src/three_channel_threshold_alarm.sv
tb/sv/tb.sv
